@@ design/lrukv_pkg.sv @@
// Shared types and constants for the LRU key/value cache.
// No dependencies; every other design file but lrukv_ram refers to it by scoped names.
package lrukv_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int KEY_W           = 32;
	localparam int VAL_W           = 32;
	localparam int CAP_W           = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// request type codes
	localparam logic REQ_GET = 1'b0;
	localparam logic REQ_SET = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic start;   // request accepted, clear scan results
		logic step;    // issue one slot read
		logic commit;  // apply update and load the response register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last;      // the read being issued is the final slot
		logic out_free;  // response register can take a new result
	} stat_t;

endpackage

@@ design/lrukv_req_if.sv @@
// Request channel: valid/ready plus get/set payload.
// Depends on lrukv_pkg for field widths.
interface lrukv_req_if;
	logic                             valid;
	logic                             ready;
	logic                             req_type;
	logic [lrukv_pkg::KEY_W-1:0]      key;
	logic signed [lrukv_pkg::VAL_W-1:0] value;

	modport source(output valid, req_type, key, value, input ready);
	modport sink(input valid, req_type, key, value, output ready);
endinterface

@@ design/lrukv_rsp_if.sv @@
// Response channel: valid/ready plus found flag and read value.
// Depends on lrukv_pkg for field widths.
interface lrukv_rsp_if;
	logic                               valid;
	logic                               ready;
	logic                               found;
	logic signed [lrukv_pkg::VAL_W-1:0] read_value;

	modport source(output valid, found, read_value, input ready);
	modport sink(input valid, found, read_value, output ready);
endinterface

@@ design/lrukv_cfg_if.sv @@
// Configuration write channel carrying the capacity register.
// Depends on lrukv_pkg for the register width.
interface lrukv_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [lrukv_pkg::CAP_W-1:0]   capacity;

	modport source(output valid, capacity, input ready);
	modport sink(input valid, capacity, output ready);
endinterface

@@ design/lru_key_value_cache.sv @@
// Top level of the LRU key/value cache: controller plus datapath.
// Depends on lrukv_pkg, the three channel interfaces, lrukv_ctrl, lrukv_dp.
//
// Usage:
//   req  - get (req_type 0) or set (req_type 1) request with key and value.
//   rsp  - one response per request: found (key was present before the
//          request) and read_value (stored value on a get hit, else zero).
//   cfg  - capacity register write; always ready, write only while idle.
//          Capacity 0 acts as 1, values above MAX_ENTRIES saturate.
// Sequence:
//   Keys/values sit in one RAM that is scanned one slot per cycle, so the
//   response register loads after the MAX_ENTRIES slot reads, the compare
//   of the last read and the commit. The next request is taken in the idle
//   cycle after commit. The RAM read port sets this pace; one request is
//   in flight at a time.
//   req.ready is high only in the idle state, but a new request is taken
//   while the previous response still waits in the output register.
// Stall: if rsp is not taken, the next request runs its scan and then holds
//   at commit until the output register frees; nothing is lost.
// Reset: arst_n clears all valid bits, recency ranks and the fill count,
//   sets capacity to 16, and drops any pending response. No clearing pass.
module lru_key_value_cache #(
	parameter int MAX_ENTRIES = lrukv_pkg::MAX_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lrukv_req_if.sink   req,
	lrukv_rsp_if.source rsp,
	lrukv_cfg_if.sink   cfg
);

	lrukv_pkg::cmd_t  cmd;
	lrukv_pkg::stat_t stat;
	logic             req_ready;

	// capacity register takes writes on any cycle
	assign cfg.ready = 1'b1;
	assign req.ready = req_ready;

	lrukv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	lrukv_dp #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.req_type      (req.req_type),
		.key           (req.key),
		.value         (req.value),
		.cfg_valid     (cfg.valid),
		.cfg_capacity  (cfg.capacity),
		.rsp_valid     (rsp.valid),
		.rsp_ready     (rsp.ready),
		.rsp_found     (rsp.found),
		.rsp_read_value(rsp.read_value)
	);

endmodule

@@ design/lrukv_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lrukv_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/lrukv_ctrl.sv @@
// Sequencer for the cache: accept, slot scan, drain, commit.
// Depends on lrukv_pkg for the command/status structs.
module lrukv_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	output lrukv_pkg::cmd_t  cmd,
	input  lrukv_pkg::stat_t stat
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		cmd.start  = 1'b0;
		cmd.step   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (stat.last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last slot's read data is compared here
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ design/lrukv_dp.sv @@
// Datapath: slot RAM, scan compare, recency ranks, fill count, capacity,
// response register. Depends on lrukv_pkg and lrukv_ram.
module lrukv_dp #(
	parameter int MAX_ENTRIES = lrukv_pkg::MAX_ENTRIES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lrukv_pkg::cmd_t                    cmd,
	output lrukv_pkg::stat_t                   stat,
	input  logic                               req_type,
	input  logic [lrukv_pkg::KEY_W-1:0]        key,
	input  logic signed [lrukv_pkg::VAL_W-1:0] value,
	input  logic                               cfg_valid,
	input  logic [lrukv_pkg::CAP_W-1:0]        cfg_capacity,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output logic                               rsp_found,
	output logic signed [lrukv_pkg::VAL_W-1:0] rsp_read_value
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int RW = AW;
	localparam int FW = $clog2(MAX_ENTRIES + 1);
	localparam int CW = (FW > lrukv_pkg::CAP_W) ? FW : lrukv_pkg::CAP_W;
	localparam int KW = lrukv_pkg::KEY_W;
	localparam int VW = lrukv_pkg::VAL_W;
	localparam int DW = KW + VW;

	// captured request
	logic          type_q;
	logic [KW-1:0] key_q;
	logic [VW-1:0] val_q;

	// scan pointer and compare stage
	logic [AW-1:0] idx_q;
	logic [AW-1:0] idx_s1;
	logic          scan_s1;

	// per-slot state
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [RW-1:0]          rank_q [MAX_ENTRIES];
	logic [FW-1:0]          fill_q;
	logic [lrukv_pkg::CAP_W-1:0] cap_q;

	// scan results
	logic          hit_q;
	logic [AW-1:0] hit_slot_q;
	logic [RW-1:0] hit_rank_q;
	logic [VW-1:0] hit_val_q;
	logic [AW-1:0] lru_slot_q;
	logic          free_q;
	logic [AW-1:0] free_slot_q;

	// response register
	logic          out_valid_q;
	logic          out_found_q;
	logic [VW-1:0] out_val_q;

	logic [DW-1:0] rd_data;
	logic [KW-1:0] rd_key;
	logic [VW-1:0] rd_val;
	logic          lane_valid;
	logic [RW-1:0] lane_rank;
	logic [FW-1:0] fill_m1;

	logic [CW-1:0] eff_cap;
	logic          evict;
	logic          upd;
	logic [AW-1:0] slot_sel;
	logic [FW-1:0] rank_lim;
	logic          ram_we;

	assign rd_key     = rd_data[DW-1 -: KW];
	assign rd_val     = rd_data[VW-1:0];
	assign lane_valid = valid_q[idx_s1];
	assign lane_rank  = rank_q[idx_s1];
	assign fill_m1    = fill_q - FW'(1);

	assign stat.last     = (idx_q == AW'(MAX_ENTRIES - 1));
	assign stat.out_free = !out_valid_q || rsp_ready;

	lrukv_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_ENTRIES)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_sel),
		.wdata({key_q, val_q}),
		.re   (cmd.step),
		.raddr(idx_q),
		.rdata(rd_data)
	);

	// capacity zero acts as one, above the slot count saturates
	always_comb begin
		priority if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (CW'(cap_q) > CW'(MAX_ENTRIES)) begin
			eff_cap = CW'(MAX_ENTRIES);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end

	// Every update is "promote slot_sel": valid ranks below rank_lim age by one.
	// Eviction reuses the LRU slot (rank fill-1); a fresh insert ages all.
	always_comb begin
		evict = (CW'(fill_q) >= eff_cap) || (CW'(fill_q) >= CW'(MAX_ENTRIES));
		upd   = hit_q || (type_q == lrukv_pkg::REQ_SET);
		priority if (hit_q) begin
			slot_sel = hit_slot_q;
			rank_lim = FW'(hit_rank_q);
		end else if (evict) begin
			slot_sel = lru_slot_q;
			rank_lim = fill_m1;
		end else begin
			slot_sel = free_slot_q;
			rank_lim = fill_q;
		end
		ram_we = cmd.commit && (type_q == lrukv_pkg::REQ_SET);
	end

	// request capture and scan payload
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			type_q <= req_type;
			key_q  <= key;
			val_q  <= value;
		end
		idx_s1 <= idx_q;
		if (scan_s1) begin
			if (lane_valid && rd_key == key_q) begin
				hit_slot_q <= idx_s1;
				hit_rank_q <= lane_rank;
				hit_val_q  <= rd_val;
			end
			if (lane_valid && FW'(lane_rank) == fill_m1) begin
				lru_slot_q <= idx_s1;
			end
			if (!lane_valid && !free_q) begin
				free_slot_q <= idx_s1;
			end
		end
		if (cmd.commit) begin
			out_found_q <= hit_q;
			out_val_q   <= (hit_q && type_q == lrukv_pkg::REQ_GET) ? hit_val_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			scan_s1     <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			valid_q     <= '0;
			fill_q      <= '0;
			cap_q       <= lrukv_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			scan_s1 <= cmd.step;
			if (cmd.start) begin
				idx_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (cmd.step) begin
				idx_q <= idx_q + AW'(1);
			end
			if (scan_s1) begin
				if (lane_valid && rd_key == key_q) begin
					hit_q <= 1'b1;
				end
				if (!lane_valid) begin
					free_q <= 1'b1;
				end
			end
			if (cfg_valid) begin
				cap_q <= cfg_capacity;
			end
			if (cmd.commit && upd) begin
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (AW'(i) == slot_sel) begin
						rank_q[i]  <= '0;
						valid_q[i] <= 1'b1;
					end else if (valid_q[i] && FW'(rank_q[i]) < rank_lim) begin
						rank_q[i] <= rank_q[i] + RW'(1);
					end
				end
				if (!hit_q && !evict) begin
					fill_q <= fill_q + FW'(1);
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid      = out_valid_q;
	assign rsp_found      = out_found_q;
	assign rsp_read_value = out_val_q;

endmodule

@@ dv/testbench.sv @@
// Self-checking bench for lru_key_value_cache: get/set requests with hit, miss and eviction.
// Depends on lrukv_pkg and the request, response and capacity channel interfaces.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES     = lrukv_pkg::MAX_ENTRIES_DEF;
	localparam int POOL_SIZE   = 24;
	localparam int PHASE_ITEMS = 110;
	localparam int HOLD_CYCLES = 600;
	localparam int CYCLE_LIMIT = 200000;

	// One request and the response it should produce.
	typedef struct {
		logic                               req_type;
		logic [lrukv_pkg::KEY_W-1:0]        key;
		logic signed [lrukv_pkg::VAL_W-1:0] value;
	} cache_req_t;

	typedef struct {
		logic                               found;
		logic signed [lrukv_pkg::VAL_W-1:0] read_value;
	} cache_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	lrukv_req_if req_ch();
	lrukv_rsp_if rsp_ch();
	lrukv_cfg_if cfg_ch();

	lru_key_value_cache u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of the cache contents, in the block's reset state.
	logic [lrukv_pkg::KEY_W-1:0] shadow_key  [ENTRIES];
	logic [lrukv_pkg::VAL_W-1:0] shadow_val  [ENTRIES];
	bit                          shadow_used [ENTRIES];
	int unsigned                 shadow_rank [ENTRIES];   // 0 = most recently touched
	int unsigned                 shadow_fill = 0;
	logic [lrukv_pkg::CAP_W-1:0] shadow_cap  = lrukv_pkg::CAP_RESET;

	cache_req_t pending_reqs[$];     // waiting for the driver
	cache_rsp_t expected_rsps[$];    // accepted, response not yet seen
	int         reqs_in_flight = 0;  // queued by stimulus, not yet accepted
	bit         req_fired      = 1'b0;
	int         error_count    = 0;
	int         cycle_count    = 0;

	int send_gap_pct  = 0;
	int rsp_stall_pct = 0;
	bit long_hold_go  = 1'b0;
	bit rsp_hold      = 1'b0;

	logic [lrukv_pkg::KEY_W-1:0] key_pool[POOL_SIZE];

	// Predict one request against the shadow cache and update it in place.
	function automatic cache_rsp_t lookup_update(input cache_req_t r);
		cache_rsp_t  res;
		int          hit;
		int          victim;
		int unsigned eff_cap;
		int unsigned worst;
		int unsigned old_rank;
		res.found      = 1'b0;
		res.read_value = '0;
		hit = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (shadow_used[i] && shadow_key[i] == r.key)
				hit = i;

		if (hit >= 0) begin
			// hit: everything newer than this entry ages by one
			res.found = 1'b1;
			old_rank = shadow_rank[hit];
			for (int i = 0; i < ENTRIES; i++)
				if (shadow_used[i] && shadow_rank[i] < old_rank)
					shadow_rank[i]++;
			shadow_rank[hit] = 0;
			if (r.req_type == lrukv_pkg::REQ_SET)
				shadow_val[hit] = r.value;
			else
				res.read_value = shadow_val[hit];
			return res;
		end

		// get miss: not found, nothing changes
		if (r.req_type == lrukv_pkg::REQ_GET)
			return res;

		// zero acts as one, anything above the slot count saturates
		if (shadow_cap == 0)
			eff_cap = 1;
		else if (shadow_cap > ENTRIES)
			eff_cap = ENTRIES;
		else
			eff_cap = 32'(shadow_cap);

		// full (or over-full after a capacity drop): drop exactly one oldest entry
		victim = -1;
		worst  = 0;
		if (shadow_fill >= eff_cap) begin
			for (int i = 0; i < ENTRIES; i++)
				if (shadow_used[i] && (victim < 0 || shadow_rank[i] > worst)) begin
					victim = i;
					worst  = shadow_rank[i];
				end
			if (victim >= 0) begin
				shadow_used[victim] = 1'b0;
				shadow_fill--;
			end
		end
		if (victim < 0)
			for (int i = 0; i < ENTRIES; i++)
				if (!shadow_used[i] && victim < 0)
					victim = i;

		for (int i = 0; i < ENTRIES; i++)
			if (shadow_used[i])
				shadow_rank[i]++;
		shadow_used[victim] = 1'b1;
		shadow_key[victim]  = r.key;
		shadow_val[victim]  = r.value;
		shadow_rank[victim] = 0;
		shadow_fill++;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
		error_count++;
	endtask

	// Request driver: holds valid until the request is taken, then maybe gaps.
	always @(negedge clk) begin
		cache_req_t nxt;
		logic       offer;
		offer = req_ch.valid;
		if (!req_ch.valid || req_fired) begin
			offer = 1'b0;
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				nxt = pending_reqs.pop_front();
				req_ch.req_type <= nxt.req_type;
				req_ch.key      <= nxt.key;
				req_ch.value    <= nxt.value;
				offer = 1'b1;
			end
		end
		req_ch.valid <= offer;
	end

	// Response sink: random stalls, plus the long hold-off when it is running.
	always @(negedge clk)
		rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);

	// Long hold-off, counted here: the sender keeps offering, so the block
	// fills its output register and its commit stage, then drops req.ready.
	initial begin
		wait (long_hold_go);
		@(negedge clk);
		rsp_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		rsp_hold <= 1'b0;
	end

	// Monitor: everything is sampled at the rising edge.
	always @(posedge clk) begin
		cache_rsp_t want;
		req_fired = 1'b0;
		if (arst_n) begin
			// responses first, so a request taken in the same cycle queues behind
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsps.size() == 0) begin
					report_mismatch("response with no request outstanding",
						rsp_ch.read_value, '0);
				end else begin
					want = expected_rsps.pop_front();
					if (rsp_ch.found !== want.found)
						report_mismatch("found", 32'(rsp_ch.found), 32'(want.found));
					if (rsp_ch.read_value !== want.read_value)
						report_mismatch("read_value", rsp_ch.read_value, want.read_value);
				end
			end
			if (cfg_ch.valid && cfg_ch.ready)
				shadow_cap = cfg_ch.capacity;
			if (req_ch.valid && req_ch.ready) begin
				expected_rsps.push_back(lookup_update('{req_ch.req_type, req_ch.key,
					req_ch.value}));
				reqs_in_flight--;
				req_fired = 1'b1;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic queue_request(input logic req_type,
			input logic [lrukv_pkg::KEY_W-1:0] key,
			input logic [lrukv_pkg::VAL_W-1:0] value);
		pending_reqs.push_back('{req_type, key, value});
		reqs_in_flight++;
	endtask

	// Checked at the falling edge, where neither counter moves.
	task automatic wait_all_done();
		do @(negedge clk);
		while (reqs_in_flight != 0 || expected_rsps.size() != 0);
	endtask

	// Only legal while idle; the monitor mirrors the write into the shadow.
	task automatic write_capacity(input logic [lrukv_pkg::CAP_W-1:0] cap);
		@(negedge clk);
		cfg_ch.capacity <= cap;
		cfg_ch.valid    <= 1'b1;
		do @(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Capacity per phase: starts below the fill left by the directed part,
	// then covers zero, saturation, one and the full slot count.
	logic [lrukv_pkg::CAP_W-1:0] phase_cap[8] =
		'{5'd3, 5'd0, 5'd31, 5'd1, 5'd16, 5'd7, 5'd2, 5'd20};

	initial begin
		int          eff;
		int          span;
		logic [31:0] val;
		logic [31:0] k;

		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = lrukv_pkg::REQ_GET;
		req_ch.key      = '0;
		req_ch.value    = '0;
		rsp_ch.ready    = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.capacity = lrukv_pkg::CAP_RESET;

		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset capacity of 16, no idling.
		queue_request(lrukv_pkg::REQ_GET, 32'h0000_0000, 32'h1111_1111); // miss, empty cache
		queue_request(lrukv_pkg::REQ_SET, 32'h0000_0000, 32'h8000_0000); // most negative value
		queue_request(lrukv_pkg::REQ_SET, 32'hFFFF_FFFF, 32'h7FFF_FFFF); // most positive value
		queue_request(lrukv_pkg::REQ_GET, 32'h0000_0000, 32'hFFFF_FFFF); // hit
		queue_request(lrukv_pkg::REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000); // hit
		queue_request(lrukv_pkg::REQ_SET, 32'h0000_0000, 32'hFFFF_FFFF); // set hit overwrites
		queue_request(lrukv_pkg::REQ_GET, 32'h0000_0000, 32'h0);
		queue_request(lrukv_pkg::REQ_GET, 32'h1234_5678, 32'h0);         // miss, not empty
		for (int i = 0; i < 14; i++)                                     // fill all 16 slots
			queue_request(lrukv_pkg::REQ_SET, 32'd100 + i, $urandom);
		queue_request(lrukv_pkg::REQ_SET, 32'd200, 32'h5A5A_A5A5);       // evicts all-ones
		queue_request(lrukv_pkg::REQ_GET, 32'hFFFF_FFFF, 32'h0);         // evicted, must miss
		queue_request(lrukv_pkg::REQ_GET, 32'h0000_0000, 32'h0);         // survived
		wait_all_done();

		// Random phases, idling cycling through none / sender / receiver / both.
		for (int p = 0; p < 8; p++) begin
			write_capacity(phase_cap[p]);
			case (p % 4)
				0: begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
				1: begin send_gap_pct = 62; rsp_stall_pct = 0;  end
				2: begin send_gap_pct = 0;  rsp_stall_pct = 62; end
				default: begin send_gap_pct = 34; rsp_stall_pct = 34; end
			endcase
			if (p == 4)
				long_hold_go = 1'b1;

			eff  = (phase_cap[p] == 0) ? 1 :
				(phase_cap[p] > ENTRIES) ? ENTRIES : phase_cap[p];
			// a key pool a little larger than the capacity keeps hits and evictions common
			span = (eff + 3 < POOL_SIZE) ? eff + 3 : POOL_SIZE - 1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				k   = ($urandom_range(99) < 85) ? key_pool[$urandom_range(span)] : $urandom;
				val = $urandom;
				case ($urandom_range(9))
					0: val = 32'h8000_0000;
					1: val = 32'h7FFF_FFFF;
					default: ;
				endcase
				queue_request(1'($urandom_range(1)), k, val);
			end
			wait_all_done();
		end

		// catch any stray response after the last expected one
		repeat (ENTRIES + 8) @(negedge clk);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
